FILE: rtl/core/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the bounded set store: operation and status
// codes, controller states and the command bundle between the two halves.
// ----------------------------------------------------------------------------
package bss_pkg;

	// Number of cells in the store.
	localparam int Capacity = 16;
	// Width of the occupancy counter, wide enough to hold Capacity itself.
	localparam int CntW = $clog2(Capacity + 1);
	// Fixed widths of the item fields.
	localparam int ValW = 32;
	localparam int OpW = 2;
	localparam int StatusW = 2;
	localparam int CountW = 5;

	typedef enum logic [OpW-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the operation and value of an accepted item
		logic exec;  // search the cells, update the store and the result
	} cmd_t;

endpackage

FILE: rtl/core/bounded_set_store_core.sv
// ----------------------------------------------------------------------------
// bounded_set_store_core
// A set of up to sixteen distinct 32-bit values kept in a packed row of
// cells with a count, supporting insert, delete and membership query.
// ----------------------------------------------------------------------------
// An item is accepted at the clock edge where start is high and busy is low,
// the next cycle compares the value against every occupied cell at once and
// updates the store, and the result is shown on status, present and count
// for exactly one cycle, marked by done. The result must be taken in that
// cycle; there is no way to hold it off. Busy is low again while the result
// is on the ports, so a new transfer can be accepted in the same cycle. The
// execute cycle is the one in which the full row of cell comparators and the
// shift network that closes a gap after a delete work together. Insert of a
// stored value reports "already present", insert into a full store reports
// "overflow", and delete of an absent value changes nothing. The operation
// code that is not used behaves as a query. After reset the store is empty.
// ----------------------------------------------------------------------------
module bounded_set_store_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [bss_pkg::OpW-1:0]           operation,
	input  logic signed [bss_pkg::ValW-1:0]   value,
	output logic                              done,
	output logic [bss_pkg::StatusW-1:0]       status,
	output logic                              present,
	output logic [bss_pkg::CountW-1:0]        count
);

	// Command bundle from the controller into the datapath.
	bss_pkg::cmd_t cmd;

	// The controller sequences accept, execute and the result strobe.
	bss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The datapath holds the cells, the count and the result registers.
	bss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.value     (value),
		.status    (status),
		.present   (present),
		.count     (count)
	);

endmodule

FILE: rtl/core/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller of the bounded set store: accepts an item, runs the execute
// state and raises the result strobe in the cycle after it.
// ----------------------------------------------------------------------------
module bss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output bss_pkg::cmd_t   cmd
);

	bss_pkg::state_t state_q;
	bss_pkg::state_t state_d;
	logic            done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bss_pkg::S_IDLE: begin
				if (start) begin
					state_d = bss_pkg::S_EXEC;
				end
			end
			bss_pkg::S_EXEC: begin
				state_d = bss_pkg::S_IDLE;
			end
			default: begin
				state_d = bss_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			bss_pkg::S_IDLE: begin
				cmd.load = start;
			end
			bss_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign done = done_q;

	// An accepted item is executed in the very next cycle.
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted item was not executed in the next cycle");

	// The strobe only ever follows an execute cycle, and never two in a row.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(cmd.exec) && !cmd.exec))
		else $error("result strobe without a preceding execute cycle");

endmodule

FILE: rtl/core/bss_dp.sv
// ----------------------------------------------------------------------------
// bss_dp
// Datapath of the bounded set store: the packed row of value cells with a
// comparator per cell, the occupancy counter and the result registers.
// ----------------------------------------------------------------------------
module bss_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bss_pkg::cmd_t                     cmd,
	input  logic [bss_pkg::OpW-1:0]           operation,
	input  logic signed [bss_pkg::ValW-1:0]   value,
	output logic [bss_pkg::StatusW-1:0]       status,
	output logic                              present,
	output logic [bss_pkg::CountW-1:0]        count
);

	bss_pkg::op_t                  op_q;
	logic [bss_pkg::ValW-1:0]      val_q;
	logic [bss_pkg::ValW-1:0]      cell_q [bss_pkg::Capacity];
	logic [bss_pkg::CntW-1:0]      occ_q;
	bss_pkg::status_t              status_q;
	logic                          present_q;

	logic [bss_pkg::Capacity-1:0]  hit;
	logic [bss_pkg::Capacity-1:0]  at_or_above;
	logic                          found;
	logic                          full;
	logic                          ins_en;
	logic                          del_en;
	bss_pkg::status_t              status_d;

	// One comparator per cell; only cells below the count take part.
	always_comb begin
		for (int k = 0; k < bss_pkg::Capacity; k++) begin
			hit[k] = (cell_q[k] == val_q) && (bss_pkg::CntW'(k) < occ_q);
		end
	end

	// Cells at or above the matching cell take their upper neighbor on delete.
	always_comb begin
		for (int k = 0; k < bss_pkg::Capacity; k++) begin
			at_or_above[k] = 1'b0;
			for (int j = 0; j <= k; j++) begin
				at_or_above[k] = at_or_above[k] | hit[j];
			end
		end
	end

	assign found = |hit;
	assign full  = (occ_q >= bss_pkg::CntW'(bss_pkg::Capacity));

	always_comb begin
		ins_en   = 1'b0;
		del_en   = 1'b0;
		status_d = bss_pkg::ST_OK;
		case (op_q)
			bss_pkg::OP_INSERT: begin
				if (found) begin
					status_d = bss_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_d = bss_pkg::ST_OVERFLOW;
				end else begin
					ins_en = 1'b1;
				end
			end
			bss_pkg::OP_DELETE: begin
				del_en = found;
			end
			default: begin
				// Query and the unused code only report presence.
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= bss_pkg::op_t'(operation);
			val_q <= value;
		end
		if (cmd.exec) begin
			status_q  <= status_d;
			present_q <= found;
			for (int k = 0; k < bss_pkg::Capacity; k++) begin
				if (ins_en && (bss_pkg::CntW'(k) == occ_q)) begin
					cell_q[k] <= val_q;
				end else if (del_en && at_or_above[k] && (k < bss_pkg::Capacity - 1)) begin
					cell_q[k] <= cell_q[(k < bss_pkg::Capacity - 1) ? k + 1 : k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.exec) begin
			if (ins_en) begin
				occ_q <= occ_q + bss_pkg::CntW'(1);
			end else if (del_en) begin
				occ_q <= occ_q - bss_pkg::CntW'(1);
			end
		end
	end

	assign status  = status_q;
	assign present = present_q;
	assign count   = bss_pkg::CountW'(occ_q);

	// The count never passes the number of cells.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= bss_pkg::CntW'(bss_pkg::Capacity))
		else $error("occupancy above capacity");

	// The count only moves in an execute cycle that inserts or deletes.
	a_occ_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> $past(cmd.exec && (ins_en || del_en)))
		else $error("occupancy changed outside an insert or delete");

endmodule
